// ----- hw/rtl/sha_pkg.sv -----
// sha_pkg: shared constants, types and round functions of the sha-256 hasher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned CountW     = 61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [1:0] {
    PAD_NONE,
    PAD_FIRST,
    PAD_EXTRA
  } pad_kind_t;

  // controller to datapath
  typedef struct packed {
    logic      put_byte;
    logic [7:0] byte_val;
    logic      load;
    logic      round;
    logic      fold;
    pad_kind_t pad;
    logic      clear;
    logic      out_step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;
    logic       long_tail;
    logic       last_round;
    logic [2:0] out_idx;
  } dp_sts_t;

  function automatic logic [31:0] iv(input logic [2:0] i);
    logic [31:0] v;
    unique case (i)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[r];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sha_if.sv -----
// sha_if: valid/ready channel interfaces for input bytes and digest words
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;
  modport source (output valid, data_byte, has_byte, is_last, input ready);
  modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sha256_stream_hasher_unit.sv -----
// sha256_stream_hasher_unit: top level of the byte-stream sha-256 hasher
// depends on sha_pkg, sha_if, sha_ctrl, sha_dp
// a byte that does not close a block is taken while the controller stays idle
// a byte that closes a block holds the input through the load, round and fold states
// last item: one or two such blocks, then eight digest words, one per cycle when ready
// synchronous active-low reset restores the initial hash and clears all counts
`timescale 1ns / 1ps
`default_nettype none
module sha256_stream_hasher_unit
  import sha_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  sha_in_if.sink   in_ch,
  sha_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    ctl_last_flag;

  sha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data_byte(in_ch.data_byte),
    .in_has_byte (in_ch.has_byte),
    .in_is_last  (in_ch.is_last),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  sha_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .digest_word(out_ch.digest_word)
  );

  assign ctl_last_flag     = (sts.out_idx == 3'd7);
  assign out_ch.word_index = sts.out_idx;
  assign out_ch.last_word  = ctl_last_flag;

endmodule
`default_nettype wire

// ----- hw/rtl/sha_ctrl.sv -----
// sha_ctrl: sequencing state machine of the hasher
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic    in_has_byte,
  input  wire logic    in_is_last,
  output logic         out_valid,
  input  wire logic    out_ready,
  output dp_cmd_t      cmd,
  input  dp_sts_t      sts
);

  ctl_state_t state_r, state_nxt;
  logic       fin_r, fin_nxt;    // finishing a message
  logic       extra_r, extra_nxt; // a second pad block follows

  logic acc;
  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fin_r   <= 1'b0;
      extra_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
      extra_r <= extra_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fin_nxt   = fin_r;
    extra_nxt = extra_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_has_byte && sts.block_full) begin
            // a last byte that closes a block needs a whole pad block after it
            state_nxt = ST_LOAD;
            fin_nxt   = in_is_last;
            extra_nxt = in_is_last;
          end else if (in_is_last) begin
            state_nxt = ST_LOAD;
            fin_nxt   = 1'b1;
            extra_nxt = sts.long_tail;
          end
        end
      end
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (sts.last_round) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (extra_r) begin
          state_nxt = ST_LOAD;
          extra_nxt = 1'b0;
        end else if (fin_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready && sts.out_idx == 3'd7) begin
          state_nxt = ST_IDLE;
          fin_nxt   = 1'b0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_OUT);
    cmd       = '0;
    cmd.byte_val = in_data_byte;
    cmd.pad   = PAD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        cmd.put_byte = acc && in_has_byte;
        // padding of the final block is laid into the buffer at accept, unless the last byte closes a block
        if (acc && in_is_last && !(in_has_byte && sts.block_full)) begin
          cmd.pad = PAD_FIRST;
        end
      end
      ST_LOAD:  cmd.load  = 1'b1;
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD: begin
        cmd.fold = 1'b1;
        if (extra_r) cmd.pad = PAD_EXTRA;
      end
      ST_OUT: begin
        cmd.out_step = out_ready;
        cmd.clear    = out_ready && sts.out_idx == 3'd7;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/sha_dp.sv -----
// sha_dp: block buffer, message schedule, round unit and hash registers
// depends on sha_pkg
`timescale 1ns / 1ps
`default_nettype none
module sha_dp
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  dp_cmd_t    cmd,
  output dp_sts_t    sts,
  output logic [31:0] digest_word
);

  logic [31:0] buf_r [16];
  logic [31:0] buf_nxt [16];
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [31:0] h_r [8];
  logic [5:0]  fill_r;
  logic [CountW-1:0] cnt_r;
  logic [CountW-1:0] cnt_now;
  logic [5:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic        pend_r; // 0x80 byte of the final message already placed
  logic [63:0] bits;
  logic [5:0]  pfill;
  logic [31:0] x2, x15, s0, s1, t1, t2, e, a;

  // length includes a byte taken in this same cycle
  assign cnt_now = cnt_r + CountW'(cmd.put_byte);
  assign bits    = {cnt_now, 3'b000};

  // place of the pad byte for the first final block
  assign pfill = cmd.put_byte ? fill_r + 6'd1 : fill_r;

  assign sts.block_full = (fill_r == 6'(BlockBytes - 1));
  assign sts.long_tail  = (pfill >= 6'd56) && !(cmd.put_byte && fill_r == 6'd63);
  assign sts.last_round = (rnd_r == 6'(Rounds - 1));
  assign sts.out_idx    = oidx_r;
  assign digest_word    = h_r[oidx_r];

  // round logic on the schedule window front
  always_comb begin
    x2  = w_r[14];
    x15 = w_r[1];
    s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    e   = v_r[4];
    a   = v_r[0];
    t1  = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & v_r[5]) ^ (~e & v_r[6]))
          + round_k(rnd_r) + w_r[0];
    t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // buffer words, byte 0 of the block in the top byte of word 0
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      buf_nxt[i] = buf_r[i];
      for (int j = 0; j < 4; j++) begin
        if (cmd.put_byte && fill_r == 6'(4*i + j))
          buf_nxt[i][31-8*j -: 8] = cmd.byte_val;
        if (cmd.pad == PAD_FIRST) begin
          if (6'(4*i + j) == pfill)
            buf_nxt[i][31-8*j -: 8] = 8'h80;
          else if (6'(4*i + j) > pfill)
            buf_nxt[i][31-8*j -: 8] = (i >= 14 && pfill < 6'd56) ?
                                      8'(bits >> (8 * (63 - (4*i + j)))) : 8'h00;
        end
        if (cmd.fold && cmd.pad == PAD_EXTRA) begin
          if (i >= 14)
            buf_nxt[i][31-8*j -: 8] = 8'(bits >> (8 * (63 - (4*i + j))));
          else if (i == 0 && j == 0 && !pend_r)
            buf_nxt[i][31-8*j -: 8] = 8'h80;
          else
            buf_nxt[i][31-8*j -: 8] = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 16; i++) buf_r[i] <= buf_nxt[i];
    if (!rst_n) begin
      fill_r <= '0;
      cnt_r  <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      pend_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= iv(3'(i));
    end else begin
      if (cmd.put_byte) begin
        fill_r <= fill_r + 6'd1;
        cnt_r  <= cnt_now;
      end
      if (cmd.pad == PAD_FIRST) pend_r <= 1'b1;
      if (cmd.load) begin
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        for (int i = 0; i < 16; i++) w_r[i] <= buf_r[i];
        rnd_r <= '0;
      end
      if (cmd.round) begin
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= s1 + w_r[9] + s0 + w_r[0];
        v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        if (cmd.pad == PAD_EXTRA) pend_r <= 1'b1;
      end
      if (cmd.out_step) oidx_r <= oidx_r + 3'd1;
      if (cmd.clear) begin
        fill_r <= '0;
        cnt_r  <= '0;
        pend_r <= 1'b0;
        for (int i = 0; i < 8; i++) h_r[i] <= iv(3'(i));
      end
    end
  end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// tb: self-checking testbench of the byte-stream sha-256 hasher
// depends on sha_pkg, sha_if and sha256_stream_hasher_unit; digests predicted in the bench
`timescale 1ns / 1ps
module tb;
  import sha_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  // digest word as seen on the result channel
  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_rec_t;

  class digest_board;
    logic [31:0] hw [8];
    logic [7:0]  buf_b [64];
    int unsigned fill;
    logic [60:0] nbytes;
    digest_rec_t pending [$];
    int unsigned errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      hw = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      foreach (buf_b[i]) buf_b[i] = 8'h00;
      fill = 0;
      nbytes = '0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] v [8];
      logic [31:0] w [64];
      logic [31:0] t1, t2, s0, s1;
      logic [31:0] k [64];
      k = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      for (int r = 0; r < 16; r++)
        w[r] = {buf_b[4*r], buf_b[4*r+1], buf_b[4*r+2], buf_b[4*r+3]};
      for (int r = 16; r < 64; r++) begin
        s1 = ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10);
        s0 = ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3);
        w[r] = s1 + w[r-7] + s0 + w[r-16];
      end
      v = hw;
      for (int r = 0; r < 64; r++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
             ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[r] + w[r];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
             ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hw[i] += v[i];
    endfunction

    function void note_item(logic [7:0] b, logic has_b, logic last);
      logic [63:0] bits;
      digest_rec_t rec;
      if (has_b) begin
        buf_b[fill] = b;
        fill++;
        nbytes++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (last) begin
        buf_b[fill] = 8'h80;
        for (int i = fill + 1; i < 64; i++) buf_b[i] = 8'h00;
        // long tail: padding spills into a second block
        if (fill >= 56) begin
          compress();
          foreach (buf_b[i]) buf_b[i] = 8'h00;
        end
        bits = {nbytes, 3'b000};
        for (int i = 0; i < 8; i++) buf_b[56+i] = bits[63-8*i -: 8];
        compress();
        for (int i = 0; i < 8; i++) begin
          rec.word = hw[i];
          rec.idx = 3'(i);
          rec.last = (i == 7);
          pending.push_back(rec);
        end
        restart();
      end
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_word(logic [31:0] word, logic [2:0] idx, logic last);
      digest_rec_t e;
      if (pending.size() == 0) begin
        report("digest word with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (word !== e.word)
        report($sformatf("word %0d: got %h want %h", e.idx, word, e.word));
      if (idx !== e.idx) report($sformatf("index: got %0d want %0d", idx, e.idx));
      if (last !== e.last) report($sformatf("last flag: got %b want %b", last, e.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned cycles = 0;
  digest_board board = new();

  sha_in_if  in_ch ();
  sha_out_if out_ch ();

  sha256_stream_hasher_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.has_byte = 1'b0;
    in_ch.is_last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall per word
  initial begin
    int unsigned gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
      board.check_word(out_ch.digest_word, out_ch.word_index, out_ch.last_word);
    end
  end

  task automatic send_item(logic [7:0] b, logic has_b, logic last);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.has_byte <= has_b;
    in_ch.is_last <= last;
    @(posedge clk iff in_ch.ready);
    board.note_item(b, has_b, last);
  endtask

  // message of n random bytes with occasional idle items, ending either on a byte or on a bare end marker
  task automatic send_message(int n);
    logic tail_marker;
    tail_marker = 1'($urandom_range(0, 1));
    if (n == 0) tail_marker = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, !tail_marker && i == n - 1);
    end
    if (tail_marker) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  initial begin
    int unsigned sent;
    int len;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // empty message, lone idle item, extreme bytes
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    drain();
    // long tail and exact block boundaries
    send_message(56);
    send_message(64);
    drain();
    sent = 0;
    while (sent < 130) begin
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(50, 70);
        default: len = $urandom_range(0, 40);
      endcase
      send_message(len);
      sent += len + 1;
      if ($urandom_range(0, 5) == 0) drain();
    end
    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
